// ----- rtl/core/dbnc_pkg.sv -----
// ----------------------------------------------------------------------------
// Key debouncer package
// Shared types, event and action codes, and sizes for the key debouncer.
// ----------------------------------------------------------------------------
package dbnc_pkg;

  localparam int unsigned NUM_KEYS = 6;
  localparam int unsigned THR_W    = 15;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned ELAPSED_W = 16;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned DATA_W   = 32;

  localparam logic [THR_W-1:0] PRESS_THR_RST = 15'd9;
  localparam logic [THR_W-1:0] HOLD_THR_RST  = 15'd249;

  // Register indexes on the configuration port
  localparam logic REG_PRESS_THR = 1'b0;
  localparam logic REG_HOLD_THR  = 1'b1;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_QUERY = 2'd1,
    ACT_PEEK  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_HOLD    = 2'd2,
    EV_RELEASE = 2'd3
  } event_e;

  typedef struct packed {
    action_e                action;
    logic [ELAPSED_W-1:0]   elapsed_ms;
    logic [NUM_KEYS-1:0]    key_pressed;
    logic [IDX_W-1:0]       key_index;
  } req_t;

  typedef struct packed {
    event_e                 key_event;
    logic                   changed_flag;
    logic [NUM_KEYS-1:0]    changed_mask;
    logic [2*NUM_KEYS-1:0]  all_events;
  } rsp_t;

  // Per-key control from the request stage
  typedef struct packed {
    logic                 tick;
    logic                 pressed;
    logic [ELAPSED_W-1:0] elapsed;
    logic                 ack;
    logic                 clear;
  } key_ctrl_t;

  // Per-key status: current and next values
  typedef struct packed {
    event_e event_q;
    logic   dirty_q;
    event_e event_d;
    logic   dirty_d;
  } key_stat_t;

endpackage

// ----- rtl/core/dbnc_cfg.sv -----
// ----------------------------------------------------------------------------
// Key debouncer configuration registers
// APB-style register file holding the press and hold thresholds.
// ----------------------------------------------------------------------------
module dbnc_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dbnc_pkg::ADDR_W-1:0]  paddr,
  input  logic [dbnc_pkg::DATA_W-1:0]  pwdata,
  output logic [dbnc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output logic [dbnc_pkg::THR_W-1:0]   press_thr_o,
  output logic [dbnc_pkg::THR_W-1:0]   hold_thr_o
);

  logic [dbnc_pkg::THR_W-1:0] press_thr_q, press_thr_d;
  logic [dbnc_pkg::THR_W-1:0] hold_thr_q, hold_thr_d;
  logic                       wr_en;
  logic                       reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  always_comb begin
    press_thr_d = press_thr_q;
    hold_thr_d  = hold_thr_q;
    if (wr_en) begin
      unique case (reg_sel)
        dbnc_pkg::REG_PRESS_THR: press_thr_d = pwdata[dbnc_pkg::THR_W-1:0];
        dbnc_pkg::REG_HOLD_THR:  hold_thr_d  = pwdata[dbnc_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      dbnc_pkg::REG_PRESS_THR:
        prdata = {{(dbnc_pkg::DATA_W-dbnc_pkg::THR_W){1'b0}}, press_thr_q};
      dbnc_pkg::REG_HOLD_THR:
        prdata = {{(dbnc_pkg::DATA_W-dbnc_pkg::THR_W){1'b0}}, hold_thr_q};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_thr_q <= dbnc_pkg::PRESS_THR_RST;
      hold_thr_q  <= dbnc_pkg::HOLD_THR_RST;
    end else begin
      press_thr_q <= press_thr_d;
      hold_thr_q  <= hold_thr_d;
    end
  end

  assign press_thr_o = press_thr_q;
  assign hold_thr_o  = hold_thr_q;

endmodule

// ----- rtl/core/dbnc_key.sv -----
// ----------------------------------------------------------------------------
// Key debouncer per-key cell
// Counter, event state and sticky changed flag of one key.
// ----------------------------------------------------------------------------
module dbnc_key (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dbnc_pkg::key_ctrl_t         ctrl_i,
  input  logic [dbnc_pkg::THR_W-1:0]  press_thr_i,
  input  logic [dbnc_pkg::THR_W-1:0]  hold_thr_i,
  output dbnc_pkg::key_stat_t         stat_o
);

  localparam logic signed [17:0] SAT_MAX = 18'sd32767;
  localparam logic signed [17:0] SAT_MIN = -18'sd32768;

  dbnc_pkg::event_e              event_q, event_d;
  logic                          dirty_q, dirty_d;
  logic signed [dbnc_pkg::CNT_W-1:0] count_q, count_d;

  logic signed [17:0] cnt_x, up_x, dn_x, el_x, pt_x, ht_x;
  logic signed [17:0] up_sx, dn_sx;
  logic signed [dbnc_pkg::CNT_W-1:0] up_sat, dn_sat;

  always_comb begin
    cnt_x  = {{2{count_q[dbnc_pkg::CNT_W-1]}}, count_q};
    el_x   = $signed({2'b00, ctrl_i.elapsed});
    pt_x   = $signed({3'b000, press_thr_i});
    ht_x   = $signed({3'b000, hold_thr_i});
    up_x   = cnt_x + el_x;
    dn_x   = cnt_x - el_x;
    up_sat = (up_x > SAT_MAX) ? SAT_MAX[dbnc_pkg::CNT_W-1:0] : up_x[dbnc_pkg::CNT_W-1:0];
    dn_sat = (dn_x < SAT_MIN) ? SAT_MIN[dbnc_pkg::CNT_W-1:0] : dn_x[dbnc_pkg::CNT_W-1:0];
    up_sx  = {{2{up_sat[dbnc_pkg::CNT_W-1]}}, up_sat};
    dn_sx  = {{2{dn_sat[dbnc_pkg::CNT_W-1]}}, dn_sat};
  end

  always_comb begin
    event_d = event_q;
    count_d = count_q;
    dirty_d = dirty_q;
    if (ctrl_i.tick) begin
      if (ctrl_i.pressed) begin
        unique case (event_q)
          dbnc_pkg::EV_NONE, dbnc_pkg::EV_RELEASE: begin
            count_d = up_sat;
            if (up_sx > pt_x) event_d = dbnc_pkg::EV_PRESS;
          end
          dbnc_pkg::EV_PRESS: begin
            count_d = up_sat;
            if (up_sx > ht_x) event_d = dbnc_pkg::EV_HOLD;
          end
          default: ;
        endcase
      end else if (event_q == dbnc_pkg::EV_PRESS || event_q == dbnc_pkg::EV_HOLD) begin
        // clamp to the press threshold first, then count down
        if (cnt_x > pt_x) begin
          count_d = pt_x[dbnc_pkg::CNT_W-1:0];
        end else begin
          count_d = dn_sat;
          if (dn_sx < 18'sd0) begin
            event_d = (event_q == dbnc_pkg::EV_PRESS) ? dbnc_pkg::EV_NONE
                                                      : dbnc_pkg::EV_RELEASE;
          end
        end
      end
      if (event_d != event_q) dirty_d = 1'b1;
    end else if (ctrl_i.ack) begin
      if (event_q == dbnc_pkg::EV_RELEASE) event_d = dbnc_pkg::EV_NONE;
      dirty_d = 1'b0;
    end else if (ctrl_i.clear) begin
      dirty_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      event_q <= dbnc_pkg::EV_NONE;
      count_q <= '0;
      dirty_q <= 1'b0;
    end else begin
      event_q <= event_d;
      count_q <= count_d;
      dirty_q <= dirty_d;
    end
  end

  assign stat_o.event_q = event_q;
  assign stat_o.dirty_q = dirty_q;
  assign stat_o.event_d = event_d;
  assign stat_o.dirty_d = dirty_d;

endmodule

// ----- rtl/core/multi_key_press_hold_debouncer_unit.sv -----
// ----------------------------------------------------------------------------
// Multi-key press/hold debouncer
// Turns six key levels into none/press/hold/release events with sticky flags.
// ----------------------------------------------------------------------------
// Each request passes through an input register and a result register, and
// all six key cells update in parallel as it moves from the first to the
// second: one request per cycle is taken while the output is not stalled.
// The input register lets a new request be taken while a finished result
// still waits on out_stall_i. Thresholds are written through the APB port
// only while no request is in flight: the user keeps to it, the block does not enforce it.
module multi_key_press_hold_debouncer_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  dbnc_pkg::req_t               in_req_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output dbnc_pkg::rsp_t               out_rsp_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dbnc_pkg::ADDR_W-1:0]  paddr,
  input  logic [dbnc_pkg::DATA_W-1:0]  pwdata,
  output logic [dbnc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  logic                       in_valid_q, in_valid_d;
  dbnc_pkg::req_t             in_q, in_d;
  logic                       out_valid_q, out_valid_d;
  dbnc_pkg::rsp_t             out_q, out_d;
  logic                       out_free, adv, accept;
  logic                       idx_ok;
  logic [dbnc_pkg::THR_W-1:0] press_thr, hold_thr;

  dbnc_pkg::key_ctrl_t        key_ctrl [dbnc_pkg::NUM_KEYS];
  dbnc_pkg::key_stat_t        key_stat [dbnc_pkg::NUM_KEYS];
  logic [dbnc_pkg::NUM_KEYS-1:0]   dirty_vec;
  logic [2*dbnc_pkg::NUM_KEYS-1:0] event_vec;

  dbnc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .press_thr_o (press_thr),
    .hold_thr_o  (hold_thr)
  );

  // Handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign adv        = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign idx_ok     = in_q.key_index < dbnc_pkg::IDX_W'(dbnc_pkg::NUM_KEYS);

  always_comb begin
    in_valid_d  = accept || (in_valid_q && !adv);
    in_d        = accept ? in_req_i : in_q;
    out_valid_d = out_free ? adv : out_valid_q;
  end

  for (genvar k = 0; k < dbnc_pkg::NUM_KEYS; k++) begin : g_key
    always_comb begin
      key_ctrl[k].tick    = adv && (in_q.action == dbnc_pkg::ACT_TICK) &&
                            (in_q.elapsed_ms != '0);
      key_ctrl[k].pressed = in_q.key_pressed[k];
      key_ctrl[k].elapsed = in_q.elapsed_ms;
      key_ctrl[k].ack     = adv && (in_q.action == dbnc_pkg::ACT_QUERY) &&
                            (in_q.key_index == dbnc_pkg::IDX_W'(k));
      key_ctrl[k].clear   = adv && (in_q.action == dbnc_pkg::ACT_CLEAR);
    end

    dbnc_key u_key (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (key_ctrl[k]),
      .press_thr_i (press_thr),
      .hold_thr_i  (hold_thr),
      .stat_o      (key_stat[k])
    );

    assign dirty_vec[k]         = key_stat[k].dirty_q;
    assign event_vec[2*k +: 2]  = key_stat[k].event_q;
  end

  // Build the result from pre-update selected key and post-update snapshot
  always_comb begin
    out_d = out_q;
    if (adv) begin
      out_d.key_event    = dbnc_pkg::EV_NONE;
      out_d.changed_flag = 1'b0;
      for (int k = 0; k < dbnc_pkg::NUM_KEYS; k++) begin
        if (idx_ok && (in_q.key_index == dbnc_pkg::IDX_W'(k))) begin
          if (in_q.action == dbnc_pkg::ACT_QUERY || in_q.action == dbnc_pkg::ACT_PEEK) begin
            out_d.key_event = key_stat[k].event_q;
          end
          if (in_q.action == dbnc_pkg::ACT_QUERY) begin
            out_d.changed_flag = key_stat[k].dirty_q;
          end
        end
        out_d.changed_mask[k]    = key_stat[k].dirty_d;
        out_d.all_events[2*k +: 2] = key_stat[k].event_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`ifndef ASSERT_OFF
  a_stall_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("input stalled with empty input register");

  a_clear_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_q.action == dbnc_pkg::ACT_CLEAR) |=> (dirty_vec == '0))
    else $error("clear left a changed flag set");

  a_zero_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_q.action == dbnc_pkg::ACT_TICK && in_q.elapsed_ms == '0)
      |=> $stable(event_vec))
    else $error("zero-time tick changed an event");

  a_query_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_q.action == dbnc_pkg::ACT_QUERY && idx_ok)
      |=> !dirty_vec[$past(in_q.key_index)])
    else $error("query did not clear the changed flag");
`endif

endmodule

// ----- sim/dbnc_event_checker.sv -----
// ----------------------------------------------------------------------------
// Key debouncer event checker
// Watches the request, result and APB channels of the key debouncer, keeps
// its own copy of the per-key counters, events and sticky flags, predicts
// the result of every accepted request and compares it field by field.
// ----------------------------------------------------------------------------
module dbnc_event_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  dbnc_pkg::req_t                in_req_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  dbnc_pkg::rsp_t                out_rsp_i,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic                          pready_i,
  input  logic [dbnc_pkg::ADDR_W-1:0]   paddr_i,
  input  logic [dbnc_pkg::DATA_W-1:0]   pwdata_i,
  input  logic [dbnc_pkg::DATA_W-1:0]   prdata_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o
);

  dbnc_pkg::event_e                    key_evt [dbnc_pkg::NUM_KEYS];
  logic signed [dbnc_pkg::CNT_W-1:0]   key_cnt [dbnc_pkg::NUM_KEYS];
  logic [dbnc_pkg::NUM_KEYS-1:0]       key_dirty;
  logic [dbnc_pkg::THR_W-1:0]          press_thr;
  logic [dbnc_pkg::THR_W-1:0]          hold_thr;
  dbnc_pkg::rsp_t                      expected_rsp_q[$];

  function automatic logic signed [dbnc_pkg::CNT_W-1:0] clamp16(input int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[dbnc_pkg::CNT_W-1:0];
  endfunction

  function automatic void advance_key(input int k, input logic pressed, input int d);
    dbnc_pkg::event_e prev;
    int     pt;
    int     ht;
    prev = key_evt[k];
    pt   = int'(press_thr);
    ht   = int'(hold_thr);
    if (pressed) begin
      if (prev == dbnc_pkg::EV_NONE || prev == dbnc_pkg::EV_RELEASE) begin
        key_cnt[k] = clamp16(int'(key_cnt[k]) + d);
        if (int'(key_cnt[k]) > pt) key_evt[k] = dbnc_pkg::EV_PRESS;
      end else if (prev == dbnc_pkg::EV_PRESS) begin
        key_cnt[k] = clamp16(int'(key_cnt[k]) + d);
        if (int'(key_cnt[k]) > ht) key_evt[k] = dbnc_pkg::EV_HOLD;
      end
    end else if (prev == dbnc_pkg::EV_PRESS || prev == dbnc_pkg::EV_HOLD) begin
      // clamp to the press threshold first, count down only from there
      if (int'(key_cnt[k]) > pt) begin
        key_cnt[k] = clamp16(pt);
      end else begin
        key_cnt[k] = clamp16(int'(key_cnt[k]) - d);
        if (int'(key_cnt[k]) < 0) begin
          key_evt[k] = (prev == dbnc_pkg::EV_PRESS) ? dbnc_pkg::EV_NONE
                                                     : dbnc_pkg::EV_RELEASE;
        end
      end
    end
    if (key_evt[k] != prev) key_dirty[k] = 1'b1;
  endfunction

  function automatic dbnc_pkg::rsp_t predict_events(input dbnc_pkg::req_t r);
    dbnc_pkg::rsp_t rsp;
    rsp = '0;
    case (r.action)
      dbnc_pkg::ACT_TICK: begin
        if (r.elapsed_ms != '0) begin
          for (int k = 0; k < dbnc_pkg::NUM_KEYS; k++) begin
            advance_key(k, r.key_pressed[k], int'(r.elapsed_ms));
          end
        end
      end
      dbnc_pkg::ACT_QUERY: begin
        if (r.key_index < dbnc_pkg::NUM_KEYS) begin
          rsp.key_event    = key_evt[r.key_index];
          rsp.changed_flag = key_dirty[r.key_index];
          if (key_evt[r.key_index] == dbnc_pkg::EV_RELEASE) begin
            key_evt[r.key_index] = dbnc_pkg::EV_NONE;
          end
          key_dirty[r.key_index] = 1'b0;
        end
      end
      dbnc_pkg::ACT_PEEK: begin
        if (r.key_index < dbnc_pkg::NUM_KEYS) rsp.key_event = key_evt[r.key_index];
      end
      default: key_dirty = '0;
    endcase
    rsp.changed_mask = key_dirty;
    for (int k = 0; k < dbnc_pkg::NUM_KEYS; k++) rsp.all_events[2*k +: 2] = key_evt[k];
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    dbnc_pkg::rsp_t want;
    logic [dbnc_pkg::THR_W-1:0] reg_val;
    if (!rst_ni) begin
      for (int k = 0; k < dbnc_pkg::NUM_KEYS; k++) begin
        key_evt[k] = dbnc_pkg::EV_NONE;
        key_cnt[k] = '0;
      end
      key_dirty = '0;
      press_thr = dbnc_pkg::PRESS_THR_RST;
      hold_thr  = dbnc_pkg::HOLD_THR_RST;
      expected_rsp_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // compare the result before predicting a request taken at the same edge
      if (out_valid_i && !out_stall_i) begin
        if (expected_rsp_q.size() == 0) begin
          $error("result with no request pending: %h", out_rsp_i);
          fail_count_o++;
        end else begin
          want = expected_rsp_q.pop_front();
          if (out_rsp_i.key_event !== want.key_event) begin
            $error("key_event: expected %0d, got %0d", want.key_event, out_rsp_i.key_event);
            fail_count_o++;
          end
          if (out_rsp_i.changed_flag !== want.changed_flag) begin
            $error("changed_flag: expected %0d, got %0d",
                   want.changed_flag, out_rsp_i.changed_flag);
            fail_count_o++;
          end
          if (out_rsp_i.changed_mask !== want.changed_mask) begin
            $error("changed_mask: expected %h, got %h",
                   want.changed_mask, out_rsp_i.changed_mask);
            fail_count_o++;
          end
          if (out_rsp_i.all_events !== want.all_events) begin
            $error("all_events: expected %h, got %h", want.all_events, out_rsp_i.all_events);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) expected_rsp_q.push_back(predict_events(in_req_i));
      if (psel_i && penable_i && pready_i) begin
        reg_val = (paddr_i[2] == dbnc_pkg::REG_PRESS_THR) ? press_thr : hold_thr;
        if (pwrite_i) begin
          if (paddr_i[2] == dbnc_pkg::REG_PRESS_THR) press_thr = pwdata_i[dbnc_pkg::THR_W-1:0];
          else hold_thr = pwdata_i[dbnc_pkg::THR_W-1:0];
        end else if (prdata_i !== dbnc_pkg::DATA_W'(reg_val)) begin
          $error("prdata: expected %h, got %h", dbnc_pkg::DATA_W'(reg_val), prdata_i);
          fail_count_o++;
        end
      end
      pending_o = expected_rsp_q.size();
    end
  end

endmodule

// ----- sim/multi_key_press_hold_debouncer_unit_test.sv -----
// ----------------------------------------------------------------------------
// Key debouncer testbench
// Drives ticks, queries, peeks and clears into the debouncer under several
// threshold settings with random gaps and stalls; the event checker predicts
// and compares every result.
// ----------------------------------------------------------------------------
module multi_key_press_hold_debouncer_unit_test;

  localparam int unsigned HOLD_OFF_CYCLES = 80;
  localparam int unsigned DRAIN_CYCLES    = 6;
  localparam int unsigned IDLE_LIMIT      = 3000;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  dbnc_pkg::req_t                in_req = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  dbnc_pkg::rsp_t                out_rsp;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [dbnc_pkg::ADDR_W-1:0]   paddr = '0;
  logic [dbnc_pkg::DATA_W-1:0]   pwdata = '0;
  logic [dbnc_pkg::DATA_W-1:0]   prdata;
  logic                          pready;
  int unsigned                   fail_count;
  int unsigned                   pending;
  logic                          quiet = 1'b0;
  logic                          hold_off_req = 1'b0;
  logic                          hold_off_done = 1'b0;
  logic [dbnc_pkg::NUM_KEYS-1:0] held_mask = '0;
  logic [dbnc_pkg::THR_W-1:0]    cur_hold_thr = dbnc_pkg::HOLD_THR_RST;
  int unsigned                   idle_cycles = 0;

  always #2 clk_i = ~clk_i;

  multi_key_press_hold_debouncer_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  dbnc_event_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_req_i     (in_req),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_rsp_i    (out_rsp),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .prdata_i     (prdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // result side: random stall bursts, plus one long hold-off on request
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req && !hold_off_done) begin
        stall_left    = HOLD_OFF_CYCLES;
        hold_off_done = 1'b1;
      end
      if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_stall  = 1'b1;
        stall_left = $urandom_range(0, 4);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("multi_key_press_hold_debouncer_unit_test: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic dbnc_pkg::req_t mk_req(input dbnc_pkg::action_e act,
                                            input logic [dbnc_pkg::ELAPSED_W-1:0] ms,
                                            input logic [dbnc_pkg::NUM_KEYS-1:0] keys,
                                            input logic [dbnc_pkg::IDX_W-1:0] idx);
    dbnc_pkg::req_t r;
    r.action      = act;
    r.elapsed_ms  = ms;
    r.key_pressed = keys;
    r.key_index   = idx;
    return r;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_req(input dbnc_pkg::req_t r);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_req   = r;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic idx,
                            input logic [dbnc_pkg::THR_W-1:0] val);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {idx, 2'b00};
    pwdata  = dbnc_pkg::DATA_W'(val);
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // write both thresholds and read each back
  task automatic set_thresholds(input logic [dbnc_pkg::THR_W-1:0] press,
                                input logic [dbnc_pkg::THR_W-1:0] hold);
    apb_access(1'b1, dbnc_pkg::REG_PRESS_THR, press);
    apb_access(1'b0, dbnc_pkg::REG_PRESS_THR, '0);
    apb_access(1'b1, dbnc_pkg::REG_HOLD_THR, hold);
    apb_access(1'b0, dbnc_pkg::REG_HOLD_THR, '0);
    cur_hold_thr = hold;
  endtask

  // keys mostly stay pressed or released across ticks, so counters build up
  task automatic run_random(input int unsigned n);
    int unsigned                    pick;
    int unsigned                    span;
    dbnc_pkg::action_e              act;
    logic [dbnc_pkg::ELAPSED_W-1:0] ms;
    logic [dbnc_pkg::IDX_W-1:0]     idx;
    span = (cur_hold_thr >> 3) + 3;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 65)      act = dbnc_pkg::ACT_TICK;
      else if (pick < 85) act = dbnc_pkg::ACT_QUERY;
      else if (pick < 95) act = dbnc_pkg::ACT_PEEK;
      else                act = dbnc_pkg::ACT_CLEAR;
      pick = $urandom_range(0, 31);
      if (pick == 0)      ms = '0;
      else if (pick == 1) ms = 16'hffff;
      else if (pick < 4)  ms = dbnc_pkg::ELAPSED_W'($urandom());
      else                ms = dbnc_pkg::ELAPSED_W'($urandom_range(1, span));
      if ($urandom_range(0, 19) == 0) begin
        held_mask = dbnc_pkg::NUM_KEYS'($urandom());
      end else begin
        for (int k = 0; k < dbnc_pkg::NUM_KEYS; k++) begin
          if ($urandom_range(0, 5) == 0) held_mask[k] = ~held_mask[k];
        end
      end
      idx = ($urandom_range(0, 4) == 0)
              ? dbnc_pkg::IDX_W'($urandom_range(0, 7))
              : dbnc_pkg::IDX_W'($urandom_range(0, dbnc_pkg::NUM_KEYS - 1));
      send_req(mk_req(act, ms, held_mask, idx));
    end
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_req(mk_req(dbnc_pkg::ACT_PEEK, 16'd0, 6'h00, 3'd0));
    send_req(mk_req(dbnc_pkg::ACT_TICK, 16'd0, 6'h3f, 3'd0));
    send_req(mk_req(dbnc_pkg::ACT_TICK, 16'd5, 6'h3f, 3'd7));
    send_req(mk_req(dbnc_pkg::ACT_TICK, 16'd10, 6'h15, 3'd0));
    send_req(mk_req(dbnc_pkg::ACT_QUERY, 16'd0, 6'h00, 3'd0));
    send_req(mk_req(dbnc_pkg::ACT_QUERY, 16'd0, 6'h00, 3'd0));
    send_req(mk_req(dbnc_pkg::ACT_TICK, 16'hffff, 6'h01, 3'd0));
    send_req(mk_req(dbnc_pkg::ACT_TICK, 16'd300, 6'h01, 3'd0));
    send_req(mk_req(dbnc_pkg::ACT_TICK, 16'd1, 6'h00, 3'd0));
    send_req(mk_req(dbnc_pkg::ACT_TICK, 16'hffff, 6'h00, 3'd0));
    send_req(mk_req(dbnc_pkg::ACT_PEEK, 16'd0, 6'h00, 3'd0));
    send_req(mk_req(dbnc_pkg::ACT_QUERY, 16'd0, 6'h00, 3'd0));
    send_req(mk_req(dbnc_pkg::ACT_QUERY, 16'd0, 6'h00, 3'd6));
    send_req(mk_req(dbnc_pkg::ACT_PEEK, 16'd0, 6'h00, 3'd7));
    send_req(mk_req(dbnc_pkg::ACT_TICK, 16'hffff, 6'h3e, 3'd0));
    send_req(mk_req(dbnc_pkg::ACT_CLEAR, 16'hffff, 6'h3f, 3'd7));
    send_req(mk_req(dbnc_pkg::ACT_TICK, 16'd1, 6'h3f, 3'd0));
    send_req(mk_req(dbnc_pkg::ACT_PEEK, 16'd0, 6'h00, 3'd5));
    send_req(mk_req(dbnc_pkg::ACT_QUERY, 16'd0, 6'h00, 3'd3));
    send_req(mk_req(dbnc_pkg::ACT_TICK, 16'd1, 6'h00, 3'd0));
    send_req(mk_req(dbnc_pkg::ACT_TICK, 16'h8000, 6'h00, 3'd0));
    send_req(mk_req(dbnc_pkg::ACT_QUERY, 16'd0, 6'h00, 3'd5));

    wait_idle();
    set_thresholds('0, '0);
    hold_off_req = 1'b1;
    run_random(250);

    wait_idle();
    set_thresholds(15'h7fff, 15'h7fff);
    run_random(200);

    wait_idle();
    set_thresholds(dbnc_pkg::THR_W'($urandom_range(1, 40)),
                   dbnc_pkg::THR_W'($urandom_range(41, 600)));
    run_random(300);

    wait_idle();
    set_thresholds(dbnc_pkg::THR_W'($urandom()), dbnc_pkg::THR_W'($urandom()));
    run_random(150);

    wait_idle();
    set_thresholds(dbnc_pkg::PRESS_THR_RST, dbnc_pkg::HOLD_THR_RST);
    quiet = 1'b1;
    run_random(300);

    wait_idle();
    if (fail_count == 0) begin
      $display("multi_key_press_hold_debouncer_unit_test: clean");
    end else begin
      $display("multi_key_press_hold_debouncer_unit_test: errors");
    end
    $finish;
  end

endmodule

// ----- multi_key_press_hold_debouncer_unit.f -----
rtl/core/dbnc_pkg.sv
rtl/core/dbnc_cfg.sv
rtl/core/dbnc_key.sv
rtl/core/multi_key_press_hold_debouncer_unit.sv
sim/dbnc_event_checker.sv
sim/multi_key_press_hold_debouncer_unit_test.sv
